// File: src/dssl_pkg.sv
// Package for the depth-sorted sprite list: entry layout, codes and helpers.
// No dependencies; used by the interfaces, dssl_coord and the top level.
`default_nettype none
package dssl_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 128;

  // Register reset values
  localparam logic [11:0] HSW_RST   = 12'd160;
  localparam logic [11:0] HSH_RST   = 12'd120;
  localparam logic [9:0]  SIMG_RST  = 10'd0;
  localparam logic [7:0]  SAX_RST   = 8'd8;
  localparam logic [7:0]  SAY_RST   = 8'd2;
  localparam logic [1:0]  SEFF_RST  = 2'd1;

  typedef enum logic [2:0] {
    REG_HSW  = 3'd0,
    REG_HSH  = 3'd1,
    REG_SIMG = 3'd2,
    REG_SAX  = 3'd3,
    REG_SAY  = 3'd4,
    REG_SEFF = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RDATA,
    S_DONE
  } fsm_t;

  // One stored list entry, position and appearance together
  typedef struct packed {
    logic [1:0]         eff;
    logic [7:0]         ay;
    logic [7:0]         ax;
    logic [9:0]         img;
    logic signed [15:0] base;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } entry_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic signed [15:0] height_z;
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic [9:0]         image_ref;
    logic [7:0]         anchor_x;
    logic [7:0]         anchor_y;
    logic [1:0]         effect;
    logic [6:0]         read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] base_line;
    logic [9:0]         out_image;
    logic [7:0]         out_anchor_x;
    logic [7:0]         out_anchor_y;
    logic [1:0]         out_effect;
    logic [7:0]         list_count;
    logic [7:0]         shadow_total;
  } result_t;

  // Clamp a 19-bit signed sum into 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/dssl_if.sv
// Handshake interfaces of the sprite list: request, result and config write.
// Depends on dssl_pkg for the payload types.
`default_nettype none
interface dssl_item_if;
  logic              valid;
  logic              ready;
  dssl_pkg::item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dssl_result_if;
  logic              valid;
  logic              ready;
  dssl_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dssl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/dssl_coord.sv
// World to screen transform with 16-bit saturation for one sprite.
// Depends on dssl_pkg (sat16).
`default_nettype none
module dssl_coord (
  input  wire logic [11:0]        half_w,
  input  wire logic [11:0]        half_h,
  input  wire logic signed [15:0] world_x,
  input  wire logic signed [15:0] world_y,
  input  wire logic signed [15:0] height_z,
  input  wire logic signed [15:0] cam_x,
  input  wire logic signed [15:0] cam_y,
  output logic signed [15:0]      screen_x,
  output logic signed [15:0]      top_line,
  output logic signed [15:0]      base_line
);
  import dssl_pkg::*;

  logic signed [18:0] sx_w;
  logic signed [18:0] base_w;
  logic signed [18:0] top_w;

  // Exact sums fit in 19 bits, then clamp
  always_comb begin
    sx_w   = $signed(19'(half_w)) + 19'(world_x) - 19'(cam_x);
    base_w = $signed(19'(half_h)) - 19'(world_y) + 19'(cam_y);
    top_w  = base_w - 19'(height_z);
  end

  assign screen_x  = sat16(sx_w);
  assign top_line  = sat16(top_w);
  assign base_line = sat16(base_w);

endmodule
`default_nettype wire

// File: src/depth_sorted_sprite_list_top.sv
// Top level of the depth-sorted sprite list: FSM, list memory, counters.
// Depends on dssl_pkg, dssl_if.sv and dssl_coord.
//
// Usage: in_req carries one request per handshake: clear (mode 0), add a
// sprite (mode 1) or read one entry in draw order (mode 2). Every request
// gives exactly one result on out_res, with the list and shadow counts after
// it. cfg_req writes the six screen/shadow registers; it is always ready and
// must only be used while the block is idle.
// Flow: one request at a time. Clear, read, skipped or refused adds pass
// from S_IDLE to S_DONE (a read through S_RDATA) and then to the output
// register. An accepted add scans and shifts the list memory one entry at a
// time (a read in S_SCAN, a write-back in S_SHIFT on a single-read-port
// memory with a registered read) from the first entry behind the shadows,
// and scans the whole list again when a shadow is pushed at the front.
// Reset clears the counts and registers; the memory needs no clearing pass,
// only entries below the count are ever read. When the receiver stalls, the
// result waits in the output register; one further request may be taken and
// worked on, and its result holds until the output register frees up.
`default_nettype none
module depth_sorted_sprite_list_top #(
  parameter int unsigned LIST_DEPTH = dssl_pkg::LIST_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dssl_item_if.sink   in_req,
  dssl_result_if.source out_res,
  dssl_cfg_if.sink    cfg_req
);
  import dssl_pkg::*;

  localparam int unsigned AW   = $clog2(LIST_DEPTH);
  localparam int unsigned CW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(LIST_DEPTH);

  // Config registers
  logic [11:0] hsw_r, hsh_r;
  logic [9:0]  simg_r;
  logic [7:0]  sax_r, say_r;
  logic [1:0]  seff_r;

  // Control and datapath state
  fsm_t               state_r, state_nxt;
  logic [CW-1:0]      count_r, sh_r, idx_r;
  logic               ins_r, shpend_r;
  entry_t             carry_r;
  logic signed [15:0] sx_r, top_r, base_r;
  status_t            res_status_r;
  entry_t             res_entry_r;
  result_t            out_r;
  logic               out_valid_r;

  // Memory
  entry_t             mem [LIST_DEPTH];
  entry_t             rd_data_r;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  entry_t             wr_data;

  logic               in_acc, out_free;
  logic signed [15:0] c_sx, c_top, c_base;
  logic [CW:0]        need_sum;
  logic               room_ok, rd_ok;
  entry_t             new_entry;
  item_t              it;

  assign it       = in_req.data;
  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign cfg_req.ready = 1'b1;

  dssl_coord u_coord (
    .half_w    (hsw_r),
    .half_h    (hsh_r),
    .world_x   (it.world_x),
    .world_y   (it.world_y),
    .height_z  (it.height_z),
    .cam_x     (it.cam_x),
    .cam_y     (it.cam_y),
    .screen_x  (c_sx),
    .top_line  (c_top),
    .base_line (c_base)
  );

  // Room and read range checks
  always_comb begin
    need_sum  = {1'b0, count_r} + ((it.height_z > 16'sd0) ? (CW + 1)'(2) : (CW + 1)'(1));
    room_ok   = (need_sum <= DEPTH_C);
    rd_ok     = (CMPW'(it.read_index) < CMPW'(count_r));
    new_entry = '{eff: it.effect, ay: it.anchor_y, ax: it.anchor_x, img: it.image_ref,
                  base: c_base, y: c_top, x: c_sx};
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsw_r  <= HSW_RST;
      hsh_r  <= HSH_RST;
      simg_r <= SIMG_RST;
      sax_r  <= SAX_RST;
      say_r  <= SAY_RST;
      seff_r <= SEFF_RST;
    end else if (cfg_req.valid) begin
      unique case (cfg_req.index)
        REG_HSW:  hsw_r  <= cfg_req.data;
        REG_HSH:  hsh_r  <= cfg_req.data;
        REG_SIMG: simg_r <= cfg_req.data[9:0];
        REG_SAX:  sax_r  <= cfg_req.data[7:0];
        REG_SAY:  say_r  <= cfg_req.data[7:0];
        REG_SEFF: seff_r <= cfg_req.data[1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (it.mode == MODE_ADD && it.height_z >= 16'sd0 && room_ok) begin
            state_nxt = S_SCAN;
          end else if (it.mode == MODE_READ && rd_ok) begin
            state_nxt = S_RDATA;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt = shpend_r ? S_SCAN : S_DONE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: state_nxt = S_SCAN;
      S_RDATA: state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(idx_r);
    wr_en   = 1'b0;
    wr_addr = AW'(idx_r);
    wr_data = carry_r;
    unique case (state_r)
      S_IDLE: begin
        rd_en   = in_acc && it.mode == MODE_READ && rd_ok;
        rd_addr = AW'(it.read_index);
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_SHIFT: wr_en = ins_r || (rd_data_r.base > top_r);
      default: ;
    endcase
  end

  // List memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sh_r        <= '0;
      out_valid_r <= 1'b0;
      shpend_r    <= 1'b0;
      ins_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register: load on a finished request, drop when taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (it.mode == MODE_CLEAR) begin
              count_r <= '0;
              sh_r    <= '0;
            end
            idx_r    <= sh_r;
            ins_r    <= 1'b0;
            shpend_r <= (it.height_z > 16'sd0);
          end
        end
        S_SCAN: begin
          if (idx_r == count_r) begin
            count_r <= count_r + 1'b1;
            if (shpend_r) begin
              shpend_r <= 1'b0;
              ins_r    <= 1'b1;
              idx_r    <= '0;
              sh_r     <= sh_r + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          if (ins_r || (rd_data_r.base > top_r)) begin
            ins_r <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sx_r         <= c_sx;
          top_r        <= c_top;
          base_r       <= c_base;
          carry_r      <= new_entry;
          res_entry_r  <= '0;
          res_status_r <= ST_OK;
          if (it.mode == MODE_ADD) begin
            if (it.height_z < 16'sd0) begin
              res_status_r <= ST_SKIPPED;
            end else if (!room_ok) begin
              res_status_r <= ST_FULL;
            end
          end else if (it.mode == MODE_READ && !rd_ok) begin
            res_status_r <= ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == count_r && shpend_r) begin
          carry_r <= '{eff: seff_r, ay: say_r, ax: sax_r, img: simg_r,
                       base: base_r, y: base_r, x: sx_r};
        end
      end
      S_SHIFT: begin
        if (ins_r || (rd_data_r.base > top_r)) begin
          carry_r <= rd_data_r;
        end
      end
      S_RDATA: res_entry_r <= rd_data_r;
      S_DONE: begin
        if (out_free) begin
          out_r.status       <= res_status_r;
          out_r.screen_x     <= res_entry_r.x;
          out_r.screen_y     <= res_entry_r.y;
          out_r.base_line    <= res_entry_r.base;
          out_r.out_image    <= res_entry_r.img;
          out_r.out_anchor_x <= res_entry_r.ax;
          out_r.out_anchor_y <= res_entry_r.ay;
          out_r.out_effect   <= res_entry_r.eff;
          out_r.list_count   <= 8'(count_r);
          out_r.shadow_total <= 8'(sh_r);
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_r;

  // Checks
  a_sh_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    sh_r <= count_r) else $error("shadow count above entry count");
  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= DEPTH_C) else $error("entry count above depth");
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("memory write outside insertion");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r)
    else $error("result not presented");

endmodule
`default_nettype wire
